// ===== design/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, opcodes and widths of the prescaled compare timer.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int CHANNELS_DEF    = 3;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int OPCODE_W    = 4;
  localparam int CHANNEL_W   = 2;
  localparam int VALUE_W     = 16;
  localparam int STATUS_W    = 1;
  localparam int COUNT_OUT_W = 16;
  localparam int FIRE_W      = 3;
  localparam int PRESCALE_W  = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-3:0] REG_PRESCALE_TOP = 1'b0;

  localparam logic [OPCODE_W-1:0] OP_TICK    = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_REL = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_ABS = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_READ    = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_START   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_STOP    = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_ZERO    = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_IRQ_ON  = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_IRQ_OFF = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK     = 1'b0;
  localparam logic [STATUS_W-1:0] ST_BAD_CH = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [CHANNEL_W-1:0] channel;
    logic [OPCODE_W-1:0]  opcode;
  } pct_cmd_t;

  typedef struct packed {
    logic [FIRE_W-1:0]      fire_mask;
    logic [COUNT_OUT_W-1:0] count_value;
    logic [STATUS_W-1:0]    status;
  } pct_result_t;

endpackage

// ===== design/pct_apb_regs.sv =====
// ----------------------------------------------------------------------------
// pct_apb_regs
// APB register file holding the prescaler top value.
// ----------------------------------------------------------------------------
module pct_apb_regs
  import pct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [PRESCALE_W-1:0] prescale_top
);

  logic [PRESCALE_W-1:0] top_r;
  logic [PRESCALE_W-1:0] top_nxt;
  logic                  wr_en;
  logic                  hit_top;

  assign hit_top = (cfg_paddr[APB_ADDR_W-1:2] == REG_PRESCALE_TOP);
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit_top;

  always_comb begin
    top_nxt = top_r;
    if (wr_en) begin
      top_nxt = cfg_pwdata[PRESCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

  assign cfg_pready   = 1'b1;
  assign cfg_prdata   = hit_top ? APB_DATA_W'(top_r) : '0;
  assign prescale_top = top_r;

endmodule

// ===== design/pct_engine.sv =====
// ----------------------------------------------------------------------------
// pct_engine
// Timer state (prescaler, main counter, compare channels) and the
// combinational next-state and result logic for one command word.
// ----------------------------------------------------------------------------
module pct_engine
  import pct_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  pct_cmd_t              cmd,
  input  logic [PRESCALE_W-1:0] prescale_top,
  output pct_result_t           result
);

  logic [PRESCALE_W-1:0]  pre_r,   pre_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] cmp_r   [CHANNELS];
  logic [COUNT_WIDTH-1:0] cmp_nxt [CHANNELS];
  logic [CHANNELS-1:0]    armed_r, armed_nxt;
  logic [CHANNELS-1:0]    pend_r,  pend_nxt;
  logic                   run_r,   run_nxt;
  logic                   irq_r,   irq_nxt;

  logic                   is_tick, is_set, wrap, adv, ch_ok;
  logic [COUNT_WIDTH-1:0] count_inc, target;
  logic [CHANNELS-1:0]    sel, match, pend_after, fire;

  assign is_tick   = (cmd.opcode == OP_TICK);
  assign is_set    = (cmd.opcode == OP_SET_REL) || (cmd.opcode == OP_SET_ABS);
  assign wrap      = (pre_r >= prescale_top);
  assign adv       = is_tick && wrap && run_r;
  assign count_inc = count_r + COUNT_WIDTH'(1);
  assign ch_ok     = (32'(cmd.channel) < 32'(CHANNELS));
  assign target    = (cmd.opcode == OP_SET_REL) ? count_r + COUNT_WIDTH'(cmd.value)
                                                : COUNT_WIDTH'(cmd.value);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sel[c]   = ch_ok && (32'(cmd.channel) == c);
      match[c] = adv && armed_r[c] && (cmp_r[c] == count_inc);
    end
  end

  always_comb begin
    pre_nxt   = pre_r;
    count_nxt = count_r;
    armed_nxt = armed_r & ~match;
    run_nxt   = run_r;
    irq_nxt   = irq_r;
    for (int c = 0; c < CHANNELS; c++) begin
      cmp_nxt[c] = (is_set && sel[c]) ? target : cmp_r[c];
    end
    // prescaler counts ticks even while the main counter is stopped
    if (is_tick) begin
      pre_nxt = wrap ? '0 : pre_r + PRESCALE_W'(1);
    end
    if (adv) begin
      count_nxt = count_inc;
    end
    case (cmd.opcode)
      OP_SET_REL, OP_SET_ABS: armed_nxt = armed_r | sel;
      OP_CLEAR:               armed_nxt = armed_r & ~sel;
      OP_START:               run_nxt   = 1'b1;
      OP_STOP:                run_nxt   = 1'b0;
      OP_ZERO:                count_nxt = '0;
      OP_IRQ_ON:              irq_nxt   = 1'b1;
      OP_IRQ_OFF:             irq_nxt   = 1'b0;
      default: ;
    endcase
    pend_after = pend_r | match;
    fire       = irq_nxt ? pend_after : '0;
    pend_nxt   = irq_nxt ? '0 : pend_after;
  end

  // map channel bits onto the fixed-width fire field
  for (genvar i = 0; i < FIRE_W; i++) begin : g_fire
    if (i < CHANNELS) begin : g_used
      assign result.fire_mask[i] = fire[i];
    end else begin : g_unused
      assign result.fire_mask[i] = 1'b0;
    end
  end

  assign result.count_value = COUNT_OUT_W'(count_nxt);
  assign result.status      = ((cmd.opcode == OP_CLEAR) || is_set) && !ch_ok ? ST_BAD_CH
                                                                            : ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r   <= '0;
      count_r <= '0;
      armed_r <= '0;
      pend_r  <= '0;
      run_r   <= 1'b0;
      irq_r   <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        cmp_r[c] <= '0;
      end
    end else if (step) begin
      pre_r   <= pre_nxt;
      count_r <= count_nxt;
      armed_r <= armed_nxt;
      pend_r  <= pend_nxt;
      run_r   <= run_nxt;
      irq_r   <= irq_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        cmp_r[c] <= cmp_nxt[c];
      end
    end
  end

  a_irq_drains: assert property (@(posedge clk) disable iff (!rst_n)
    step && irq_nxt |=> pend_r == '0)
    else $error("pending channels kept while interrupts enabled");

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_tick && !run_r |=> $stable(count_r))
    else $error("main counter moved while stopped");

  a_pend_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
    step && !adv |=> (pend_r & ~$past(pend_r)) == '0)
    else $error("channel became pending without a counter step");

  // with delivery off, newly pending channels are exactly the ones just disarmed that were not already pending
  a_fire_was_armed: assert property (@(posedge clk) disable iff (!rst_n)
    step && adv && !irq_nxt |=>
      (pend_r & ~$past(pend_r)) == ($past(armed_r) & ~armed_r & ~$past(pend_r)))
    else $error("pending set without matching armed channel");

endmodule

// ===== design/prescaled_compare_timer_core.sv =====
// Pipeline: a command word accepted on the input is held in the input register;
//   its result word is then registered in the output register once that slot is free.
// Throughput: one word per cycle while out_tready stays high; the timer state and
//   compare logic update in one pass from the input register, so back-to-back ticks are handled.
// Reset: synchronous active-low rst_n clears counters, channels, flags and the
//   prescale_top register; both pipeline registers come up empty.
// ----------------------------------------------------------------------------
// prescaled_compare_timer_core
// Prescaled 16-bit timer with one-shot output-compare channels, driven by a
// stream of command words and answering each with one result word.
// ----------------------------------------------------------------------------
module prescaled_compare_timer_core
  import pct_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // opcode[3:0], channel[5:4], value[21:6]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status[0], count_value[16:1], fire_mask[19:17]
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CMD_W = $bits(pct_cmd_t);
  localparam int RES_W = $bits(pct_result_t);

  logic [PRESCALE_W-1:0] prescale_top;

  logic        in_valid_r, in_valid_nxt;
  pct_cmd_t    in_cmd_r,   in_cmd_nxt;
  logic        out_valid_r, out_valid_nxt;
  pct_result_t out_res_r,   out_res_nxt;
  pct_result_t result;
  logic        advance;

  pct_apb_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .prescale_top (prescale_top)
  );

  // advance the held command into the timer when the result slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_cmd_nxt    = in_cmd_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    // drop the result word once taken, unless a new one replaces it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = result;
      in_valid_nxt  = 1'b0;
    end
    // capture a new command word
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_cmd_nxt   = in_tdata[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_cmd_r  <= in_cmd_nxt;
    out_res_r <= out_res_nxt;
  end

  pct_engine #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .cmd          (in_cmd_r),
    .prescale_top (prescale_top),
    .result       (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r[RES_W-1:0]);

endmodule
